// ===== rtl/mkte_pkg.sv =====
`timescale 1ns / 1ps

package mkte_pkg;

  localparam logic [2:0] CMD_KEY     = 3'd0;
  localparam logic [2:0] CMD_WHEEL   = 3'd1;
  localparam logic [2:0] CMD_BUTTON  = 3'd2;
  localparam logic [2:0] CMD_TIMEOUT = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [6:0] BTN_ROW = 7'd0;
  localparam logic [6:0] BTN_END = 7'd4;
  localparam logic [6:0] BTN_MAX = 7'd3;

  localparam logic [3:0] KEY_MAX = 4'd8;
  localparam logic [1:0] ROW_MAX = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] DIGIT_BASE = 8'h31;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } mkte_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    mkte_res_t  r0;
    mkte_res_t  r1;
  } mkte_pair_t;

  localparam logic [0:8][0:15][7:0] ALPHA_TAB = {
    8'h20, 8'h08, 8'h2E, 8'h2C, 8'h31, 8'h30, 8'h21, 8'h3F,
    8'h0A, 8'h3A, 8'h3B, 8'h22, 8'h27, 8'hA1, 8'hBF, 8'h00,
    8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43, 8'h32, 8'h40,
    8'h2F, 8'h5C, 8'h5F, 8'h7C, 8'hA6, 8'h00, 8'h00, 8'h00,
    8'h64, 8'h65, 8'h66, 8'h44, 8'h45, 8'h46, 8'h33, 8'h23,
    8'hBA, 8'hAA, 8'hB9, 8'hB2, 8'hB3, 8'h00, 8'h00, 8'h00,
    8'h67, 8'h68, 8'h69, 8'h47, 8'h48, 8'h49, 8'h34, 8'h24,
    8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h6A, 8'h6B, 8'h6C, 8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h25,
    8'hBC, 8'hBD, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h6D, 8'h6E, 8'h6F, 8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h5E,
    8'h7E, 8'h60, 8'hB4, 8'hA8, 8'hB8, 8'h00, 8'h00, 8'h00,
    8'h70, 8'h71, 8'h72, 8'h73, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h37, 8'h26, 8'hA7, 8'hB6, 8'hB0, 8'hA9, 8'hAE, 8'hB5,
    8'h74, 8'h75, 8'h76, 8'h54, 8'h55, 8'h56, 8'h38, 8'h2A,
    8'h2B, 8'h2D, 8'h3D, 8'h3C, 8'h3E, 8'h00, 8'h00, 8'h00,
    8'h77, 8'h78, 8'h79, 8'h7A, 8'h57, 8'h58, 8'h59, 8'h5A,
    8'h39, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h00
  };

  localparam logic [0:8][4:0] ALPHA_LEN = {
    5'd15, 5'd13, 5'd13, 5'd12, 5'd11, 5'd13, 5'd16, 5'd13, 5'd15
  };

  localparam logic [0:10][7:0] NUM_KEY0 = {
    8'h31, 8'h30, 8'h2E, 8'h2D, 8'h08, 8'h45, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E
  };
  localparam logic [4:0] NUM_KEY0_LEN = 5'd11;

  function automatic logic [4:0] str_len(input logic mode, input logic [3:0] key);
    logic [3:0] k;
    k = (key > KEY_MAX) ? 4'd0 : key;
    if (mode) begin
      str_len = (k == 4'd0) ? NUM_KEY0_LEN : 5'd1;
    end else begin
      str_len = ALPHA_LEN[k];
    end
  endfunction

  function automatic logic [7:0] str_char(input logic mode, input logic [3:0] key,
                                          input logic [4:0] idx);
    logic [3:0] k;
    logic [4:0] len;
    logic [4:0] i;
    k   = (key > KEY_MAX) ? 4'd0 : key;
    len = str_len(mode, k);
    i   = (idx >= len) ? len - 5'd1 : idx;
    if (mode) begin
      str_char = (k == 4'd0) ? NUM_KEY0[i[3:0]] : DIGIT_BASE + {4'd0, k};
    end else begin
      str_char = ALPHA_TAB[k][i[3:0]];
    end
  endfunction

  // eighths of the wheel, rounded; wrap past the last slot goes to the first
  function automatic logic [3:0] wheel_key(input logic [6:0] pos);
    if (pos < 7'd6) begin
      wheel_key = 4'd1;
    end else if (pos < 7'd18) begin
      wheel_key = 4'd2;
    end else if (pos < 7'd30) begin
      wheel_key = 4'd5;
    end else if (pos < 7'd42) begin
      wheel_key = 4'd8;
    end else if (pos < 7'd54) begin
      wheel_key = 4'd7;
    end else if (pos < 7'd66) begin
      wheel_key = 4'd6;
    end else if (pos < 7'd78) begin
      wheel_key = 4'd3;
    end else if (pos < 7'd90) begin
      wheel_key = 4'd0;
    end else begin
      wheel_key = 4'd1;
    end
  endfunction

endpackage

// ===== rtl/mkte_core.sv =====
`timescale 1ns / 1ps

module mkte_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2:0]          in_cmd,
  input  logic [6:0]          in_value,
  input  logic                cfg_wr,
  input  logic                cfg_mode,
  input  logic                take_ok,
  output logic                push,
  output mkte_pkg::mkte_pair_t pair
);

  logic       vld_r, vld_nxt;
  logic [2:0] cmd_r;
  logic [6:0] value_r;
  logic       mode_r;
  logic [1:0] row_r, row_nxt;
  logic [3:0] key_r, key_nxt;
  logic [4:0] pos_r, pos_nxt;

  assign in_tready = !vld_r || take_ok;
  assign push      = vld_r && take_ok;
  assign vld_nxt   = in_tready ? in_tvalid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      mode_r <= 1'b0;
      row_r  <= 2'd0;
      key_r  <= 4'd0;
      pos_r  <= 5'd0;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr) begin
        mode_r <= cfg_mode;
      end
      if (push) begin
        row_r <= row_nxt;
        key_r <= key_nxt;
        pos_r <= pos_nxt;
      end
    end
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
  end

  always_comb begin
    logic       pend;
    logic [7:0] commit_code;
    logic       press_en;
    logic       commit_en;
    logic [3:0] pkey;
    logic [3:0] row3;
    logic [5:0] step;
    pend        = (pos_r != 5'd0);
    commit_code = mkte_pkg::str_char(mode_r, key_r, pos_r - 5'd1);
    press_en    = 1'b0;
    commit_en   = 1'b0;
    pkey        = 4'd0;
    row3        = {1'b0, row_r, 1'b0} + {2'd0, row_r};
    step        = {1'b0, pos_r} + 6'd1;
    row_nxt     = row_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    pair        = '0;

    case (cmd_r)
      mkte_pkg::CMD_KEY: begin
        press_en = (value_r <= {3'd0, mkte_pkg::KEY_MAX});
        pkey     = value_r[3:0];
      end
      mkte_pkg::CMD_WHEEL: begin
        press_en = 1'b1;
        pkey     = mkte_pkg::wheel_key(value_r);
      end
      mkte_pkg::CMD_BUTTON: begin
        if (value_r == mkte_pkg::BTN_ROW) begin
          commit_en = 1'b1;
          row_nxt   = (row_r >= mkte_pkg::ROW_MAX) ? 2'd0 : row_r + 2'd1;
        end else if (value_r == mkte_pkg::BTN_END) begin
          pair.cnt     = 2'd1;
          pair.r0.kind = mkte_pkg::KIND_END;
          pair.r0.code = 8'd0;
        end else if (value_r <= mkte_pkg::BTN_MAX) begin
          press_en = 1'b1;
          pkey     = row3 + {2'd0, value_r[1:0]} - 4'd1;
        end
      end
      mkte_pkg::CMD_TIMEOUT: begin
        commit_en = 1'b1;
      end
      mkte_pkg::CMD_CLEAR: begin
        row_nxt = 2'd0;
        key_nxt = 4'd0;
        pos_nxt = 5'd0;
      end
      default: begin
      end
    endcase

    if (commit_en) begin
      if (pend) begin
        pair.cnt     = 2'd1;
        pair.r0.kind = mkte_pkg::KIND_CHAR;
        pair.r0.code = commit_code;
      end
      pos_nxt = 5'd0;
    end

    if (press_en) begin
      if (pkey != 4'd0 && mode_r) begin
        // numeric digit: flush pending, then the digit itself
        pair.r0.kind = mkte_pkg::KIND_CHAR;
        pair.r1.kind = mkte_pkg::KIND_CHAR;
        if (pend) begin
          pair.cnt     = 2'd2;
          pair.r0.code = commit_code;
          pair.r1.code = mkte_pkg::DIGIT_BASE + {4'd0, pkey};
        end else begin
          pair.cnt     = 2'd1;
          pair.r0.code = mkte_pkg::DIGIT_BASE + {4'd0, pkey};
        end
        key_nxt = pkey;
        pos_nxt = 5'd0;
      end else if (pkey == key_r) begin
        pos_nxt = (step > {1'b0, mkte_pkg::str_len(mode_r, pkey)}) ? 5'd1 : step[4:0];
      end else begin
        if (pend) begin
          pair.cnt     = 2'd1;
          pair.r0.kind = mkte_pkg::KIND_CHAR;
          pair.r0.code = commit_code;
        end
        key_nxt = pkey;
        pos_nxt = 5'd1;
      end
    end
  end

endmodule

// ===== rtl/mkte_out.sv =====
`timescale 1ns / 1ps

module mkte_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mkte_pkg::mkte_pair_t pair,
  output logic                 take_ok,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  logic [1:0]          cnt_r, cnt_nxt;
  mkte_pkg::mkte_res_t head_r, head_nxt;
  mkte_pkg::mkte_res_t tail_r, tail_nxt;
  logic                load;
  logic                pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head_r.code;
  assign out_tuser  = head_r.kind;
  assign out_tlast  = (cnt_r == 2'd1);
  assign pop        = out_tvalid && out_tready;
  assign take_ok    = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign load       = push && (pair.cnt != 2'd0);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (load) begin
      cnt_nxt  = pair.cnt;
      head_nxt = pair.r0;
      tail_nxt = pair.r1;
    end else if (pop) begin
      if (cnt_r == 2'd2) begin
        cnt_nxt  = 2'd1;
        head_nxt = tail_r;
      end else begin
        cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result count out of range");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_tready)))
    else $error("result pair loaded over undelivered results");

  a_pair_chars: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pair.cnt == 2'd2) |-> (pair.r0.kind == mkte_pkg::KIND_CHAR &&
                                    pair.r1.kind == mkte_pkg::KIND_CHAR))
    else $error("end marker inside a result pair");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && out_tready) |=> (cnt_r == 2'd1 && $past(tail_r) == head_r))
    else $error("second result of a pair lost");

endmodule

// ===== rtl/multitap_keypad_text_entry.sv =====
`timescale 1ns / 1ps
// channel | dir | transaction
// in_     | in  | tdata[2:0] cmd, tdata[9:3] value
// out_    | out | tdata code, tuser kind, tlast last
// cfg_    | in  | tdata[0] numeric_mode
//
// Each event's results pass from the input register into the result buffer once the buffer can take them.
// An event that commits a character and emits a digit holds its two results
// in the output buffer; others hold at most one.
// rst_n (synchronous) clears row, key, pending position and numeric_mode.
// A stalled out_ side holds the next event in the input register.

module multitap_keypad_text_entry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] cmd, [9:3] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] code
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // [0] numeric_mode
);

  logic                 take_ok;
  logic                 push;
  mkte_pkg::mkte_pair_t pair;

  assign cfg_tready = 1'b1;

  mkte_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tdata[2:0]),
    .in_value  (in_tdata[9:3]),
    .cfg_wr    (cfg_tvalid && cfg_tready),
    .cfg_mode  (cfg_tdata[0]),
    .take_ok   (take_ok),
    .push      (push),
    .pair      (pair)
  );

  mkte_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pair       (pair),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
